[design/oscl_pkg.sv]
package oscl_pkg;

    // sample and coefficient formats
    localparam int SAMPLE_BITS = 24;
    localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;
    localparam int COEF_FRAC   = 22;
    localparam int DRIVE_FRAC  = 11;
    localparam int OUT_FRAC    = 14;
    localparam int GAIN_W      = 16;
    localparam int B0_W        = 23;
    localparam int COEF_W      = 24;
    localparam int STATE_W     = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // soft clip table
    localparam int CLIP_DEPTH      = 1024;
    localparam int CLIP_DEPTH_LOG2 = 10;
    localparam int CLIP_RANGE_LOG2 = 3;
    localparam int CLIP_AW         = CLIP_DEPTH_LOG2 + 1;
    localparam int TAB_W           = 32;
    localparam int TAB_FRAC        = 31;
    localparam int INTERP_W        = 16;
    localparam int DRV_W           = SAMPLE_BITS + GAIN_W;
    localparam int POS_SHIFT       = SAMPLE_FRAC + DRIVE_FRAC + CLIP_RANGE_LOG2
                                     - INTERP_W - CLIP_DEPTH_LOG2;
    localparam int CLIP_SHIFT      = TAB_FRAC - SAMPLE_FRAC;

    // shared multiplier
    localparam int MUL_A_W = STATE_W + 1;
    localparam int MUL_B_W = COEF_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int BX_W    = B0_W + 1 + SAMPLE_BITS;

    // register reset values
    localparam logic [GAIN_W-1:0]        RST_DRIVE_GAIN = 16'd10240;
    localparam logic [GAIN_W-1:0]        RST_OUT_GAIN   = 16'd16384;
    localparam logic [B0_W-1:0]          RST_COEF_B0    = 23'd299393;
    localparam logic signed [COEF_W-1:0] RST_COEF_A1    = -24'sd6710886;
    localparam logic signed [COEF_W-1:0] RST_COEF_A2    = 24'sd2910686;
    localparam logic                     RST_BYPASS_ON  = 1'b0;
    localparam logic                     RST_MONO_ON    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE_GAIN,
        CFG_OUT_GAIN,
        CFG_COEF_B0,
        CFG_COEF_A1,
        CFG_COEF_A2,
        CFG_BYPASS_ON,
        CFG_MONO_ON
    } t_cfg_idx;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DRV,
        OP_ADDR,
        OP_INTERP,
        OP_CLIP,
        OP_BX,
        OP_Y,
        OP_A1,
        OP_N1,
        OP_N2,
        OP_SAT
    } t_dp_op;

    typedef struct packed {
        t_dp_op             op;
        logic               ch;
        logic               fill_en;
        logic [CLIP_AW-1:0] fill_addr;
        logic               emit;
    } t_dp_cmd;

    typedef struct packed {
        logic bypass_on;
    } t_dp_sts;

    typedef logic [TAB_W-1:0] t_clip_tab [0:CLIP_DEPTH];

    localparam logic [63:0] CLIP_STEP = (64'd1 << (TAB_FRAC + CLIP_RANGE_LOG2)) / CLIP_DEPTH;

    // q0.31 product, rounded to nearest
    function automatic logic [63:0] tab_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << (TAB_FRAC - 1))) >> TAB_FRAC;
    endfunction

    // shift-subtract quotient, used only while the table is elaborated
    function automatic logic [63:0] tab_div(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[63:0], num[k]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tanh on [0, 8]: taylor series for one step, then the addition formula
    function automatic t_clip_tab build_clip_tab();
        t_clip_tab   tab;
        logic [63:0] h;
        logic [63:0] h2;
        logic [63:0] h3;
        logic [63:0] h5;
        logic [63:0] h7;
        logic [63:0] h9;
        logic [63:0] t;
        logic [63:0] cur;
        logic [63:0] den;
        logic [63:0] q;
        h  = CLIP_STEP;
        h2 = tab_mul(h, h);
        h3 = tab_mul(h, h2);
        h5 = tab_mul(h3, h2);
        h7 = tab_mul(h5, h2);
        h9 = tab_mul(h7, h2);
        t  = h - (h3 + 64'd1) / 64'd3 + (64'd2 * h5 + 64'd7) / 64'd15
               - (64'd17 * h7 + 64'd157) / 64'd315 + (64'd62 * h9 + 64'd1417) / 64'd2835;
        tab[0] = '0;
        for (int i = 0; i < CLIP_DEPTH; i++) begin
            cur = 64'(tab[i]);
            den = (64'd1 << TAB_FRAC) + tab_mul(cur, t);
            q   = tab_div(((cur + t) << TAB_FRAC) + (den >> 1), den);
            if (q > ((64'd1 << TAB_FRAC) - 64'd1)) begin
                q = (64'd1 << TAB_FRAC) - 64'd1;
            end
            tab[i + 1] = q[TAB_W-1:0];
        end
        return tab;
    endfunction

    localparam t_clip_tab CLIP_TAB = build_clip_tab();

endpackage

[design/oscl_ram.sv]
module oscl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[design/oscl_datapath.sv]
module oscl_datapath import oscl_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    input  logic                      i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [2*SAMPLE_BITS-1:0]  i_in_data,
    output logic [2*SAMPLE_BITS-1:0]  o_out_data,
    output logic                      o_ram_we,
    output logic [CLIP_AW-1:0]        o_ram_waddr,
    output logic [TAB_W-1:0]          o_ram_wdata,
    output logic [CLIP_AW-1:0]        o_ram_raddr_a,
    output logic [CLIP_AW-1:0]        o_ram_raddr_b,
    input  logic [TAB_W-1:0]          i_ram_rdata_a,
    input  logic [TAB_W-1:0]          i_ram_rdata_b
);

    localparam logic signed [STATE_W-1:0]     ST_MAX  = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0]     ST_MIN  = {1'b1, {(STATE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [PROD_W-1:0]      RND_COEF = PROD_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [PROD_W-1:0]      RND_OUT  = PROD_W'(1) <<< (OUT_FRAC - 1);
    localparam logic [TAB_W:0]                RND_CLIP = (TAB_W+1)'(1) << (CLIP_SHIFT - 1);
    localparam logic [SAMPLE_BITS:0]          CLIP_CAP = (SAMPLE_BITS+1)'(SMP_MAX);
    localparam int                            IDX_LSB  = POS_SHIFT + INTERP_W;
    localparam int                            OVER_LSB = IDX_LSB + CLIP_DEPTH_LOG2;

    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [PROD_W-1:0] v
    );
        if (v > PROD_W'(ST_MAX)) begin
            return ST_MAX;
        end else if (v < PROD_W'(ST_MIN)) begin
            return ST_MIN;
        end
        return v[STATE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [PROD_W-1:0] v
    );
        if (v > PROD_W'(SMP_MAX)) begin
            return SMP_MAX;
        end else if (v < PROD_W'(SMP_MIN)) begin
            return SMP_MIN;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    // configuration registers
    logic [GAIN_W-1:0]        r_drive_gain;
    logic [GAIN_W-1:0]        r_out_gain;
    logic [B0_W-1:0]          r_coef_b0;
    logic signed [COEF_W-1:0] r_coef_a1;
    logic signed [COEF_W-1:0] r_coef_a2;
    logic                     r_bypass_on;
    logic                     r_mono_on;

    // filter state per channel
    logic signed [STATE_W-1:0] r_d1 [2];
    logic signed [STATE_W-1:0] r_d2 [2];

    // working registers
    logic signed [SAMPLE_BITS-1:0] r_l;
    logic signed [SAMPLE_BITS-1:0] r_r;
    logic signed [PROD_W-1:0]      r_prod;
    logic [INTERP_W-1:0]           r_frac;
    logic                          r_neg;
    logic [TAB_W-1:0]              r_lo;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [BX_W-1:0]        r_bx;
    logic signed [STATE_W-1:0]     r_y;
    logic [2*SAMPLE_BITS-1:0]      r_out_data;
    logic                          r_wr_en;
    logic [CLIP_AW-1:0]            r_wr_addr;
    logic [TAB_W-1:0]              r_wr_data;

    logic signed [SAMPLE_BITS-1:0] in_l;
    logic signed [SAMPLE_BITS-1:0] in_r;
    logic signed [SAMPLE_BITS:0]   mono_sum;
    logic signed [SAMPLE_BITS-1:0] s_cur;
    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]      prod_full;
    logic                          mul_en;
    logic signed [DRV_W-1:0]       drv;
    logic [DRV_W-1:0]              mag;
    logic                          clip_over;
    logic [CLIP_DEPTH_LOG2-1:0]    idx;
    logic [INTERP_W-1:0]           frac;
    logic [TAB_W-1:0]              diff;
    logic [TAB_W:0]                interp_v;
    logic [TAB_W:0]                clip_rnd;
    logic [SAMPLE_BITS:0]          clip_mag;
    logic [SAMPLE_BITS:0]          clip_cap;
    logic signed [SAMPLE_BITS-1:0] clip_x;
    logic signed [BX_W-1:0]        bx_new;
    logic signed [STATE_W-1:0]     d1_cur;
    logic signed [STATE_W-1:0]     d2_cur;
    logic signed [PROD_W-1:0]      y_acc;
    logic signed [PROD_W-1:0]      n1_acc;
    logic signed [PROD_W-1:0]      n1_sum;
    logic signed [PROD_W-1:0]      n2_acc;
    logic signed [PROD_W-1:0]      o_acc;

    // input split and mono average, rounded toward minus infinity
    assign in_l     = signed'(i_in_data[SAMPLE_BITS-1:0]);
    assign in_r     = signed'(i_in_data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign mono_sum = (SAMPLE_BITS+1)'(in_l) + (SAMPLE_BITS+1)'(in_r);
    assign s_cur    = i_cmd.ch ? r_r : r_l;

    // table address from the drive product magnitude
    assign drv       = signed'(r_prod[DRV_W-1:0]);
    assign mag       = drv[DRV_W-1] ? (~drv + 1'b1) : drv;
    assign clip_over = |mag[DRV_W-1:OVER_LSB];
    assign idx       = mag[OVER_LSB-1:IDX_LSB];
    assign frac      = mag[IDX_LSB-1:POS_SHIFT];

    assign o_ram_raddr_a = clip_over ? CLIP_AW'(CLIP_DEPTH) : {1'b0, idx};
    assign o_ram_raddr_b = clip_over ? CLIP_AW'(CLIP_DEPTH) : ({1'b0, idx} + 1'b1);

    // interpolation step and rounding to the sample format
    assign diff     = (i_ram_rdata_b > i_ram_rdata_a) ? (i_ram_rdata_b - i_ram_rdata_a) : '0;
    assign interp_v = {1'b0, r_lo} + {1'b0, r_prod[INTERP_W+TAB_W-1:INTERP_W]};
    assign clip_rnd = interp_v + RND_CLIP;
    assign clip_mag = (SAMPLE_BITS+1)'(clip_rnd >> CLIP_SHIFT);
    assign clip_cap = (clip_mag > CLIP_CAP) ? CLIP_CAP : clip_mag;
    assign clip_x   = r_neg ? -signed'(clip_cap[SAMPLE_BITS-1:0])
                            : signed'(clip_cap[SAMPLE_BITS-1:0]);

    // biquad sums, each rounded once from q.45, and the output gain product rounded from q.37
    assign bx_new = signed'(r_prod[BX_W-1:0]);
    assign d1_cur = r_d1[i_cmd.ch];
    assign d2_cur = r_d2[i_cmd.ch];
    assign y_acc  = (PROD_W'(bx_new) + (PROD_W'(d1_cur) <<< COEF_FRAC) + RND_COEF) >>> COEF_FRAC;
    assign n1_acc = ((PROD_W'(r_bx) <<< 1) - r_prod + RND_COEF) >>> COEF_FRAC;
    assign n1_sum = n1_acc + PROD_W'(d2_cur);
    assign n2_acc = (PROD_W'(r_bx) - r_prod + RND_COEF) >>> COEF_FRAC;
    assign o_acc  = (r_prod + RND_OUT) >>> OUT_FRAC;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_DRV: begin
                mul_a = MUL_A_W'(s_cur);
                mul_b = MUL_B_W'(signed'({1'b0, r_drive_gain}));
            end
            OP_INTERP: begin
                mul_a = signed'({1'b0, diff});
                mul_b = MUL_B_W'(signed'({1'b0, r_frac}));
            end
            OP_BX: begin
                mul_a = MUL_A_W'(r_x);
                mul_b = MUL_B_W'(signed'({1'b0, r_coef_b0}));
            end
            OP_A1: begin
                mul_a = MUL_A_W'(r_y);
                mul_b = MUL_B_W'(r_coef_a1);
            end
            OP_N1: begin
                mul_a = MUL_A_W'(r_y);
                mul_b = MUL_B_W'(r_coef_a2);
            end
            OP_N2: begin
                mul_a = MUL_A_W'(r_y);
                mul_b = MUL_B_W'(signed'({1'b0, r_out_gain}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_en    = i_cmd.op inside {OP_DRV, OP_INTERP, OP_BX, OP_A1, OP_N1, OP_N2};
    assign prod_full = mul_a * mul_b;

    // configuration writes, extra bits dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_gain <= RST_DRIVE_GAIN;
            r_out_gain   <= RST_OUT_GAIN;
            r_coef_b0    <= RST_COEF_B0;
            r_coef_a1    <= RST_COEF_A1;
            r_coef_a2    <= RST_COEF_A2;
            r_bypass_on  <= RST_BYPASS_ON;
            r_mono_on    <= RST_MONO_ON;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DRIVE_GAIN: r_drive_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_OUT_GAIN:   r_out_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_COEF_B0:    r_coef_b0    <= i_cfg_data[B0_W-1:0];
                CFG_COEF_A1:    r_coef_a1    <= signed'(i_cfg_data[COEF_W-1:0]);
                CFG_COEF_A2:    r_coef_a2    <= signed'(i_cfg_data[COEF_W-1:0]);
                CFG_BYPASS_ON:  r_bypass_on  <= i_cfg_data[0];
                CFG_MONO_ON:    r_mono_on    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // filter delays, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1[0] <= '0;
            r_d1[1] <= '0;
            r_d2[0] <= '0;
            r_d2[1] <= '0;
        end else begin
            if (i_cmd.op == OP_N1) begin
                r_d1[i_cmd.ch] <= sat_state(n1_sum);
            end
            if (i_cmd.op == OP_N2) begin
                r_d2[i_cmd.ch] <= sat_state(n2_acc);
            end
        end
    end

    // table fill write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_en <= 1'b0;
        end else begin
            r_wr_en <= i_cmd.fill_en;
        end
        r_wr_addr <= i_cmd.fill_addr;
        r_wr_data <= CLIP_TAB[i_cmd.fill_addr];
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= prod_full;
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_l <= r_mono_on ? mono_sum[SAMPLE_BITS:1] : in_l;
                r_r <= r_mono_on ? mono_sum[SAMPLE_BITS:1] : in_r;
            end
            OP_ADDR: begin
                r_neg  <= drv[DRV_W-1];
                r_frac <= clip_over ? '0 : frac;
            end
            OP_INTERP: begin
                r_lo <= i_ram_rdata_a;
            end
            OP_CLIP: begin
                r_x <= clip_x;
            end
            OP_Y: begin
                r_bx <= bx_new;
                r_y  <= sat_state(y_acc);
            end
            OP_SAT: begin
                if (i_cmd.ch) begin
                    r_r <= sat_sample(o_acc);
                end else begin
                    r_l <= sat_sample(o_acc);
                end
            end
            default: ;
        endcase
        if (i_cmd.emit) begin
            r_out_data <= {r_r, r_l};
        end
    end

    assign o_sts.bypass_on = r_bypass_on;
    assign o_out_data      = r_out_data;
    assign o_ram_we        = r_wr_en;
    assign o_ram_waddr     = r_wr_addr;
    assign o_ram_wdata     = r_wr_data;

endmodule

[design/oscl_ctrl.sv]
module oscl_ctrl import oscl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_FILL,
        S_IDLE,
        S_DRV,
        S_ADDR,
        S_INTERP,
        S_CLIP,
        S_BX,
        S_Y,
        S_A1,
        S_N1,
        S_N2,
        S_SAT,
        S_EMIT
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic               r_ch;
    logic               n_ch;
    logic [CLIP_AW-1:0] r_fill_cnt;
    logic [CLIP_AW-1:0] n_fill_cnt;
    logic               r_out_valid;
    logic               n_out_valid;

    // next state and datapath command
    always_comb begin
        n_state         = r_state;
        n_ch            = r_ch;
        n_fill_cnt      = r_fill_cnt;
        n_out_valid     = r_out_valid && !i_out_ready;
        o_cmd.op        = OP_NONE;
        o_cmd.ch        = r_ch;
        o_cmd.fill_en   = 1'b0;
        o_cmd.fill_addr = r_fill_cnt;
        o_cmd.emit      = 1'b0;
        case (r_state)
            S_FILL: begin
                o_cmd.fill_en = 1'b1;
                n_fill_cnt    = r_fill_cnt + 1'b1;
                if (r_fill_cnt == CLIP_AW'(CLIP_DEPTH)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_ch     = 1'b0;
                    n_state  = i_sts.bypass_on ? S_EMIT : S_DRV;
                end
            end
            S_DRV: begin
                o_cmd.op = OP_DRV;
                n_state  = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.op = OP_ADDR;
                n_state  = S_INTERP;
            end
            S_INTERP: begin
                o_cmd.op = OP_INTERP;
                n_state  = S_CLIP;
            end
            S_CLIP: begin
                o_cmd.op = OP_CLIP;
                n_state  = S_BX;
            end
            S_BX: begin
                o_cmd.op = OP_BX;
                n_state  = S_Y;
            end
            S_Y: begin
                o_cmd.op = OP_Y;
                n_state  = S_A1;
            end
            S_A1: begin
                o_cmd.op = OP_A1;
                n_state  = S_N1;
            end
            S_N1: begin
                o_cmd.op = OP_N1;
                n_state  = S_N2;
            end
            S_N2: begin
                o_cmd.op = OP_N2;
                n_state  = S_SAT;
            end
            S_SAT: begin
                o_cmd.op = OP_SAT;
                if (!r_ch) begin
                    n_ch    = 1'b1;
                    n_state = S_DRV;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hand the pair to the output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_ch        <= 1'b0;
            r_fill_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_fill_cnt  <= n_fill_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[design/overdrive_soft_clip_lowpass_unit.sv]
// Stereo overdrive: optional mono average, then per channel drive gain, tanh soft clip from an
// interpolated 1025-entry table, a two-pole low-pass biquad and output gain with saturation.
// One stereo pair is processed at a time; the channels go one after the other through a single
// shared multiplier, each through the states drive, address, interpolate, clip, bx, y, a1, n1,
// n2 and saturate; in bypass a pair goes from idle straight to emit. The finished pair sits in an
// output register, so the next pair can be taken while it waits. After reset the tanh table
// memory is loaded from constants, one entry per cycle, all 1025 entries; no pair is taken during
// that pass, while configuration writes are accepted at any time (o_cfg_ready is always high).
module overdrive_soft_clip_lowpass_unit import oscl_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // in_left [23:0], in_right [47:24]
    input  logic [2*SAMPLE_BITS-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // out_left [23:0], out_right [47:24]
    output logic [2*SAMPLE_BITS-1:0] m_axis_tdata,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    t_dp_cmd            cmd;
    t_dp_sts            sts;
    logic               ram_we;
    logic [CLIP_AW-1:0] ram_waddr;
    logic [TAB_W-1:0]   ram_wdata;
    logic [CLIP_AW-1:0] ram_raddr_a;
    logic [CLIP_AW-1:0] ram_raddr_b;
    logic [TAB_W-1:0]   ram_rdata_a;
    logic [TAB_W-1:0]   ram_rdata_b;

    assign o_cfg_ready = 1'b1;

    // sequencer
    oscl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // arithmetic and registers
    oscl_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_data     (s_axis_tdata),
        .o_out_data    (m_axis_tdata),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr_a (ram_raddr_a),
        .o_ram_raddr_b (ram_raddr_b),
        .i_ram_rdata_a (ram_rdata_a),
        .i_ram_rdata_b (ram_rdata_b)
    );

    // tanh table
    oscl_ram #(
        .WIDTH (TAB_W),
        .DEPTH (CLIP_DEPTH + 1)
    ) u_clip_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

endmodule

[design/oscl_checker.sv]
module oscl_checker import oscl_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [2*SAMPLE_BITS-1:0] m_axis_tdata
);

    // one pair in work: no transaction right after another
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a pair is in work");

    // a new result appears only after the input side was closed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result shown without work cycle");

    // reset empties the output register
    assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // stalled result stays offered
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // stalled result keeps its data
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

endmodule

bind overdrive_soft_clip_lowpass_unit oscl_checker u_oscl_checker (.*);
